[hdl/tccw_pkg.sv]
// Shared types and constants for the text console cursor writer.
`timescale 1ns / 1ps

package tccw_pkg;

	localparam int CHAR_W  = 8;
	localparam int ATTR_W  = 8;
	localparam int INDEX_W = 11;
	localparam int VALUE_W = 16;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

	localparam int TAB_STEP = 4;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

	typedef struct packed {
		logic               wr;
		logic [INDEX_W-1:0] index;
		logic [CHAR_W-1:0]  chr;
	} cell_write_t;

endpackage

[hdl/tccw_cfg.sv]
// APB register block holding the text attribute.
`timescale 1ns / 1ps

module tccw_cfg
	import tccw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [ATTR_W-1:0] attr
);

	localparam logic REG_TEXT_ATTR = 1'b0;

	logic [ATTR_W-1:0] attr_q;
	logic              sel_attr;

	assign sel_attr = (paddr[ADDR_W-1] == REG_TEXT_ATTR);
	assign pready   = 1'b1;
	assign attr     = attr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (psel && penable && pwrite && pready && sel_attr) begin
			attr_q <= pwdata[ATTR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_attr) begin
			prdata = {{(DATA_W-ATTR_W){1'b0}}, attr_q};
		end
	end

endmodule

[hdl/tccw_cursor.sv]
// Cursor state and next-cursor / cell-write logic for one character.
`timescale 1ns / 1ps

module tccw_cursor
	import tccw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [CHAR_W-1:0] char_code,
	output cell_write_t       cell_wr
);

	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W  = $clog2(COLUMNS + 1);
	localparam int PROD_W = (ROW_W + COL_W + 1 > INDEX_W) ? ROW_W + COL_W + 1 : INDEX_W;

	logic [ROW_W-1:0]  row_q, row_nxt, row_inc, wr_row;
	logic [COL_W-1:0]  col_q, col_nxt, wr_col, tab_col;
	logic [COL_W:0]    tab_sum;
	logic              full;
	logic              wr;
	logic [CHAR_W-1:0] chr;
	logic [PROD_W-1:0] prod;

	always_comb begin
		row_inc = (row_q == ROW_W'(ROWS - 1)) ? '0 : row_q + 1'b1;
		tab_sum = {1'b0, col_q} + (COL_W+1)'(TAB_STEP);
		tab_col = (tab_sum > (COL_W+1)'(COLUMNS)) ? COL_W'(COLUMNS) : tab_sum[COL_W-1:0];
		full    = (col_q >= COL_W'(COLUMNS));

		row_nxt = row_q;
		col_nxt = col_q;
		wr_row  = row_q;
		wr_col  = col_q;
		wr      = 1'b0;
		chr     = char_code;

		case (char_code)
			CH_NEWLINE: begin
				row_nxt = row_inc;
				col_nxt = '0;
			end
			CH_TAB: begin
				col_nxt = tab_col;
			end
			CH_BACKSPACE: begin
				col_nxt = (col_q == '0) ? '0 : col_q - 1'b1;
				wr_col  = col_nxt;
				wr      = 1'b1;
				chr     = CH_SPACE;
			end
			default: begin
				wr_row  = full ? row_inc : row_q;
				wr_col  = full ? '0 : col_q;
				row_nxt = wr_row;
				col_nxt = wr_col + 1'b1;
				wr      = 1'b1;
			end
		endcase

		prod = PROD_W'(wr_row) * PROD_W'(COLUMNS) + PROD_W'(wr_col);

		cell_wr.wr    = wr;
		cell_wr.index = prod[INDEX_W-1:0];
		cell_wr.chr   = chr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (step) begin
			row_q <= row_nxt;
			col_q <= col_nxt;
		end
	end

endmodule

[hdl/text_console_cursor_writer_unit.sv]
// Top level of the text console cursor writer.
// Usage:
//   Character requests come in on char_valid/char_ready/char_code, one byte
//   each. Backspace, tab and newline move the cursor; every other byte is
//   printable. Printable bytes and backspace give one cell write request on
//   cell_valid/cell_ready with cell_index (row * COLUMNS + column) and
//   cell_value (attribute in the high byte, character in the low byte).
//   Tab and newline give no cell write.
//   A byte taken into the input register moves on to the output register, where
//   its cell write shows, once that register is empty or draining. One byte per
//   cycle is taken sustained while the receiver does not stall; the cursor update
//   and index multiply-add are combinational between the two registers.
//   When the receiver stalls, the output register holds its request and the
//   input register takes one more byte; char_ready then drops until the
//   output drains.
//   Reset clears the cursor to row 0, column 0, empties both registers and
//   sets the attribute to 7. The attribute register sits at byte address 0 of
//   the APB port; the user writes it only while no byte is in flight (unchecked).
`timescale 1ns / 1ps

module text_console_cursor_writer_unit
	import tccw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               char_valid,
	output logic               char_ready,
	input  logic [CHAR_W-1:0]  char_code,
	output logic               cell_valid,
	input  logic               cell_ready,
	output logic [INDEX_W-1:0] cell_index,
	output logic [VALUE_W-1:0] cell_value
);

	logic [ATTR_W-1:0]  attr;
	logic               valid_s1;
	logic [CHAR_W-1:0]  char_s1;
	logic               valid_s2;
	logic [INDEX_W-1:0] index_s2;
	logic [VALUE_W-1:0] value_s2;
	logic               adv;
	cell_write_t        cell_wr;

	tccw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.attr    (attr)
	);

	tccw_cursor #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.char_code (char_s1),
		.cell_wr   (cell_wr)
	);

	assign adv        = valid_s1 && (!valid_s2 || cell_ready);
	assign char_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			char_s1 <= char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= cell_wr.wr;
		end else if (cell_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cell_wr.wr) begin
			index_s2 <= cell_wr.index;
			value_s2 <= {attr, cell_wr.chr};
		end
	end

	assign cell_valid = valid_s2;
	assign cell_index = index_s2;
	assign cell_value = value_s2;

endmodule

[hdl/tccw_checker.sv]
// Port-level checks for the text console cursor writer, bound to the top level.
`timescale 1ns / 1ps

module tccw_checker
	import tccw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
)
(
	input logic               clk,
	input logic               arst_n,
	input logic               cell_valid,
	input logic               cell_ready,
	input logic [INDEX_W-1:0] cell_index,
	input logic [VALUE_W-1:0] cell_value
);

	localparam int  CELLS    = COLUMNS * ROWS;
	localparam logic WIDE_GRID = (CELLS > (1 << INDEX_W));

	// stalled write request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_ready |=> cell_valid && $stable(cell_index) && $stable(cell_value))
		else $error("cell write request changed while stalled");

	// written cell lies on the grid
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid |-> WIDE_GRID || (int'(cell_index) < CELLS))
		else $error("cell index outside the grid");

	// tab and newline never write a cell
	a_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid |-> (cell_value[CHAR_W-1:0] != CH_TAB) &&
			(cell_value[CHAR_W-1:0] != CH_NEWLINE))
		else $error("control character written to a cell");

	a_reset: assert property (@(posedge clk)
		!arst_n |-> !cell_valid)
		else $error("cell write request during reset");

endmodule

bind text_console_cursor_writer_unit tccw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tccw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cell_valid (cell_valid),
	.cell_ready (cell_ready),
	.cell_index (cell_index),
	.cell_value (cell_value)
);

[verif/text_console_cursor_writer_unit_test.sv]
// Testbench for text_console_cursor_writer_unit: character requests in, predicted cell writes checked.
`timescale 1ns / 1ps

module text_console_cursor_writer_unit_test;
	import tccw_pkg::*;

	localparam int COLS = 80;
	localparam int ROWS = 25;
	localparam int WATCHDOG_CYCLES = 4000;
	localparam int DRAIN_CYCLES = 4;
	localparam logic [ADDR_W-1:0] REG_TEXT_ATTRIBUTE = 3'd0;

	typedef struct {
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] value;
	} cell_write_exp_t;

	logic               clk;
	logic               arst_n     = 1'b1;
	logic               psel       = 1'b0;
	logic               penable    = 1'b0;
	logic               pwrite     = 1'b0;
	logic [ADDR_W-1:0]  paddr      = '0;
	logic [DATA_W-1:0]  pwdata     = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               char_valid = 1'b0;
	logic               char_ready;
	logic [CHAR_W-1:0]  char_code  = '0;
	logic               cell_valid;
	logic               cell_ready = 1'b0;
	logic [INDEX_W-1:0] cell_index;
	logic [VALUE_W-1:0] cell_value;

	cell_write_exp_t cell_writes_due[$];
	int          cursor_row;
	int          cursor_col;
	logic [7:0]  text_attr;
	int          errors;
	int          chars_sent;
	int          cells_checked;
	int          attr_settings;
	int          src_idle_pct;
	int          sink_stall_pct;
	int          hold_req;
	int          hold_left;
	int          quiet_cycles;

	text_console_cursor_writer_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_code  (char_code),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.cell_index (cell_index),
		.cell_value (cell_value)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// cursor update and cell write prediction for one accepted byte
	task automatic predict_cell_write(input logic [7:0] c);
		cell_write_exp_t e;
		logic [7:0] shown;
		bit writes;
		int idx;
		shown = c;
		writes = 1'b0;
		if (c == CH_NEWLINE) begin
			cursor_col = 0;
			cursor_row = (cursor_row + 1 >= ROWS) ? 0 : cursor_row + 1;
		end else if (c == CH_TAB) begin
			cursor_col = cursor_col + TAB_STEP;
			if (cursor_col > COLS)
				cursor_col = COLS;
		end else if (c == CH_BACKSPACE) begin
			if (cursor_col > 0)
				cursor_col = cursor_col - 1;
			shown = CH_SPACE;
			writes = 1'b1;
		end else begin
			if (cursor_col >= COLS) begin
				cursor_col = 0;
				cursor_row = (cursor_row + 1 >= ROWS) ? 0 : cursor_row + 1;
			end
			writes = 1'b1;
		end
		if (writes) begin
			idx = cursor_row * COLS + cursor_col;
			e.index = idx[INDEX_W-1:0];
			e.value = {text_attr, shown};
			cell_writes_due.push_back(e);
		end
		if (writes && c != CH_BACKSPACE)
			cursor_col = cursor_col + 1;
	endtask

	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct)
			gap++;
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_code  <= c;
		do
			@(posedge clk);
		while (!char_ready);
		predict_cell_write(c);
		chars_sent++;
	endtask

	task automatic drain();
		char_valid <= 1'b0;
		while (cell_writes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_read_check(input logic [DATA_W-1:0] exp_val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= REG_TEXT_ATTRIBUTE;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== exp_val) begin
			$error("text_attribute: expected %0d, got %0d", exp_val, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_attribute(input logic [7:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_TEXT_ATTRIBUTE;
		pwdata  <= {{(DATA_W-8){1'b0}}, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		text_attr = v;
		attr_settings++;
		@(posedge clk);
		apb_read_check({{(DATA_W-8){1'b0}}, v});
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_char(input int nl_pct);
		int r;
		r = $urandom_range(99);
		if (r < nl_pct)
			return CH_NEWLINE;
		if (r < nl_pct + 12)
			return CH_TAB;
		if (r < nl_pct + 20)
			return CH_BACKSPACE;
		return 8'($urandom_range(255));
	endfunction

	task automatic run_random(input int n, input int nl_pct);
		repeat (n) send_char(rand_char(nl_pct));
		drain();
	endtask

	task automatic test_reset_attribute();
		apb_read_check({{(DATA_W-8){1'b0}}, ATTR_RESET});
		@(posedge clk);
	endtask

	task automatic test_directed();
		logic [7:0] seq[$];
		seq = '{8'h41, CH_BACKSPACE, CH_BACKSPACE, 8'h00, 8'hFF, 8'h80, 8'h7F,
			8'h55, 8'hAA, CH_TAB, 8'h7A, CH_NEWLINE, CH_BACKSPACE, CH_TAB,
			CH_TAB, CH_BACKSPACE, 8'h0B, 8'h07, CH_NEWLINE, CH_NEWLINE, 8'h20};
		foreach (seq[i])
			send_char(seq[i]);
		drain();
	endtask

	task automatic test_attribute_extremes();
		set_attribute(8'h00);
		send_char(8'hFF);
		send_char(CH_BACKSPACE);
		drain();
		set_attribute(8'hFF);
		send_char(8'h00);
		send_char(CH_BACKSPACE);
		drain();
	endtask

	task automatic test_steady_stream();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		run_random(160, 1);
	endtask

	task automatic test_sender_gaps();
		set_attribute(8'($urandom_range(255)));
		src_idle_pct = 53;
		sink_stall_pct = 0;
		run_random(160, 8);
	endtask

	task automatic test_receiver_stalls();
		set_attribute(8'($urandom_range(255)));
		src_idle_pct = 0;
		sink_stall_pct = 53;
		run_random(160, 1);
	endtask

	task automatic test_light_idling();
		set_attribute(8'h00);
		src_idle_pct = 6;
		sink_stall_pct = 6;
		run_random(160, 4);
	endtask

	task automatic test_backpressure();
		set_attribute(8'hFF);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_req = 300;
		run_random(160, 2);
	endtask

	task automatic test_row_wrap();
		set_attribute(ATTR_RESET);
		src_idle_pct = 6;
		sink_stall_pct = 6;
		run_random(150, 15);
	endtask

	// receiver: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			cell_ready <= 1'b0;
		end else
			cell_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && cell_valid && cell_ready) begin
			if (cell_writes_due.size() == 0) begin
				$error("cell write request with none expected: index %0d value %0h",
					cell_index, cell_value);
				errors++;
			end else begin
				if (cell_index !== cell_writes_due[0].index) begin
					$error("cell_index: expected %0d, got %0d",
						cell_writes_due[0].index, cell_index);
					errors++;
				end
				if (cell_value !== cell_writes_due[0].value) begin
					$error("cell_value: expected %0h, got %0h",
						cell_writes_due[0].value, cell_value);
					errors++;
				end
				void'(cell_writes_due.pop_front());
				cells_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((char_valid && char_ready) || (cell_valid && cell_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("text_console_cursor_writer_unit test failed");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cursor_row = 0;
		cursor_col = 0;
		text_attr = ATTR_RESET;
		errors = 0;
		chars_sent = 0;
		cells_checked = 0;
		attr_settings = 1;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_req = 0;
		hold_left = 0;
		quiet_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_attribute();
		test_directed();
		test_attribute_extremes();
		test_steady_stream();
		test_sender_gaps();
		test_receiver_stalls();
		test_light_idling();
		test_backpressure();
		test_row_wrap();

		drain();
		repeat (10) @(posedge clk);
		if (cell_writes_due.size() != 0) begin
			$error("%0d cell write requests never arrived", cell_writes_due.size());
			errors++;
		end
		$display("Covered %0d character requests and %0d cell writes over %0d attribute values,",
			chars_sent, cells_checked, attr_settings);
		$display("with column and row wrap, tab saturation, backspace clamp and output backpressure.");
		if (errors == 0)
			$display("text_console_cursor_writer_unit test passed");
		else
			$display("text_console_cursor_writer_unit test failed");
		$finish;
	end

endmodule

[text_console_cursor_writer_unit.f]
hdl/tccw_pkg.sv
hdl/tccw_cfg.sv
hdl/tccw_cursor.sv
hdl/text_console_cursor_writer_unit.sv
hdl/tccw_checker.sv
verif/text_console_cursor_writer_unit_test.sv
